### rtl/olmp_pkg.sv
// Package for oriented local max pooling: field widths, codes, sequencer states
// and the elaboration-time fixed-point trig used to build the offset coefficients.
// No dependencies.
package olmp_pkg;

    localparam int NUM_ORIENT_DEF       = 16;
    localparam int MAX_SIZE_DEF         = 64;
    localparam int MAX_LOC_SHIFT_DEF    = 7;
    localparam int MAX_ORIENT_SHIFT_DEF = 3;
    localparam int VALUE_WIDTH_DEF      = 16;

    localparam int ORIENT_W    = 4;
    localparam int COORD_W     = 7;
    localparam int SHIFT_W     = 7;
    localparam int LOC_LIM_W   = 3;
    localparam int ORI_LIM_W   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [COORD_W-1:0]   WIDTH_RST      = 7'd64;
    localparam logic [COORD_W-1:0]   HEIGHT_RST     = 7'd64;
    localparam logic [LOC_LIM_W-1:0] LOC_LIMIT_RST  = 3'd3;
    localparam logic [ORI_LIM_W-1:0] ORI_LIMIT_RST  = 2'd1;

    localparam int TRIG_W       = 32;
    localparam int Q_FRAC       = 30;
    localparam int TAYLOR_TERMS = 10;

    localparam longint          Q30_ONE   = 64'sd1 << Q_FRAC;
    localparam longint unsigned Q30_ONE_U = 64'd1 << Q_FRAC;
    localparam longint          Q30_HALF  = Q30_ONE / 2;
    localparam longint unsigned PI_Q30    = 64'd3373259426;

    localparam longint unsigned TC_DIV [TAYLOR_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned TS_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH        = 3'd0,
        CFG_HEIGHT       = 3'd1,
        CFG_LOC_LIMIT    = 3'd2,
        CFG_ORIENT_LIMIT = 3'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } trig_t;

    // fold the angle pi*o/n into the first quarter turn
    function automatic int fold_p(input int o, input int n);
        int p;
        p = o;
        if (2 * p > n)
        begin
            p = n - p;
        end
        return p;
    endfunction

    function automatic int fold_a(input int o, input int n);
        int p;
        p = fold_p(o, n);
        if (4 * p > n)
        begin
            return n - 2 * p;
        end
        return p;
    endfunction

    function automatic int fold_b(input int o, input int n);
        int p;
        p = fold_p(o, n);
        if (4 * p > n)
        begin
            return 2 * n;
        end
        return n;
    endfunction

    // cos and sin in Q30 of an angle xv (Q30 radians) up to pi/4
    function automatic trig_t taylor_q30(input longint unsigned xv);
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint          sc;
        longint          ss;
        trig_t           r;
        x2 = (xv * xv) >> Q_FRAC;
        tc = Q30_ONE_U;
        ts = xv;
        sc = Q30_ONE;
        ss = longint'(xv);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            tc = ((tc * x2) >> Q_FRAC) / TC_DIV[k-1];
            ts = ((ts * x2) >> Q_FRAC) / TS_DIV[k-1];
            if ((k & 1) != 0)
            begin
                sc = sc - longint'(tc);
                ss = ss - longint'(ts);
            end
            else
            begin
                sc = sc + longint'(tc);
                ss = ss + longint'(ts);
            end
        end
        r.c = sc;
        r.s = ss;
        return r;
    endfunction

    // cos and sin of pi*o/n in Q30; xv is the folded angle in Q30 radians
    function automatic trig_t trig_q30(input int o, input int n, input longint unsigned xv);
        int    a;
        int    b;
        bit    neg;
        bit    swp;
        trig_t t;
        trig_t r;
        neg = (2 * o > n);
        swp = (4 * fold_p(o, n) > n);
        a   = fold_a(o, n);
        b   = fold_b(o, n);
        if (a == 0)
        begin
            t.c = Q30_ONE;
            t.s = '0;
        end
        else
        begin
            t = taylor_q30(xv);
            if (6 * a == b)
            begin
                t.s = Q30_HALF;
            end
        end
        if (swp)
        begin
            r.c = t.s;
            r.s = t.c;
        end
        else
        begin
            r = t;
        end
        if (neg)
        begin
            r.c = -r.c;
        end
        return r;
    endfunction

endpackage

### rtl/olmp_offset_unit.sv
// Shared offset unit: per-orientation cos/sin coefficient table built at
// elaboration and one multiply with round-half-up to a pixel offset.
// Depends on olmp_pkg.
module olmp_offset_unit
    import olmp_pkg::*;
#(
    parameter int NUM_ORIENT    = NUM_ORIENT_DEF,
    parameter int MAX_LOC_SHIFT = MAX_LOC_SHIFT_DEF
)
(
    input  logic                                  sel_sin,
    input  logic [$clog2(NUM_ORIENT)-1:0]         orient_idx,
    input  logic signed [$clog2(MAX_LOC_SHIFT+1):0] step,
    output logic signed [$clog2(MAX_LOC_SHIFT+1):0] offset
);

    localparam int D_W    = $clog2(MAX_LOC_SHIFT + 1) + 1;
    localparam int PROD_W = TRIG_W + D_W;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (Q_FRAC - 1);

    logic signed [TRIG_W-1:0] cos_tab [NUM_ORIENT];
    logic signed [TRIG_W-1:0] sin_tab [NUM_ORIENT];
    logic signed [TRIG_W-1:0] coef;
    logic signed [PROD_W-1:0] step_ext;
    logic signed [PROD_W-1:0] coef_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rsum;

    for (genvar o = 0; o < NUM_ORIENT; o++)
    begin : g_trig
        localparam int              FA = fold_a(o, NUM_ORIENT);
        localparam int              FB = fold_b(o, NUM_ORIENT);
        localparam longint unsigned XV = (PI_Q30 * 64'(FA)) / 64'(FB);
        localparam trig_t           TV = trig_q30(o, NUM_ORIENT, XV);
        assign cos_tab[o] = TRIG_W'(TV.c);
        assign sin_tab[o] = TRIG_W'(TV.s);
    end

    assign coef     = sel_sin ? sin_tab[orient_idx] : cos_tab[orient_idx];
    assign step_ext = PROD_W'(step);
    assign coef_ext = PROD_W'(coef);
    assign prod     = step_ext * coef_ext;
    assign rsum     = prod + HALF;
    assign offset   = rsum[Q_FRAC +: D_W];

endmodule

### rtl/oriented_local_max_pooling.sv
// Write item: writes may follow back to back.
// Query item: in_stall stays high until the result is loaded into the output register;
// the next item is taken after that. Each location step uses the shared multiplier for
// the x offset and then the y offset, and makes one map read per in-image shift.
// Reset clears control state and restores the register defaults; the map is not cleared.
module oriented_local_max_pooling
    import olmp_pkg::*;
#(
    parameter int NUM_ORIENT       = NUM_ORIENT_DEF,
    parameter int MAX_SIZE         = MAX_SIZE_DEF,
    parameter int MAX_LOC_SHIFT    = MAX_LOC_SHIFT_DEF,
    parameter int MAX_ORIENT_SHIFT = MAX_ORIENT_SHIFT_DEF,
    parameter int VALUE_WIDTH      = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [ORIENT_W-1:0]           orient,
    input  logic [COORD_W-1:0]            x,
    input  logic [COORD_W-1:0]            y,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] max_response,
    output logic [SHIFT_W-1:0]            best_shift,
    output logic                          found,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int OI_W      = $clog2(NUM_ORIENT);
    localparam int CI_W      = $clog2(MAX_SIZE);
    localparam int ADDR_W    = OI_W + 2 * CI_W;
    localparam int MAP_DEPTH = 1 << ADDR_W;
    localparam int D_W       = $clog2(MAX_LOC_SHIFT + 1) + 1;
    localparam int A_W       = $clog2(2 * MAX_LOC_SHIFT + 2);
    localparam int B_W       = $clog2(2 * MAX_ORIENT_SHIFT + 2);
    localparam int SC_W      = $clog2((2 * MAX_LOC_SHIFT + 1) * (2 * MAX_ORIENT_SHIFT + 1) + 1);
    localparam int P_W       = COORD_W + 2;
    localparam logic signed [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // configuration
    logic [COORD_W-1:0]   width_reg;
    logic [COORD_W-1:0]   height_reg;
    logic [LOC_LIM_W-1:0] loc_lim_reg;
    logic [ORI_LIM_W-1:0] ori_lim_reg;
    logic [COORD_W-1:0]   w_eff;
    logic [COORD_W-1:0]   h_eff;
    logic [LOC_LIM_W-1:0] l_eff;
    logic [ORI_LIM_W-1:0] o_eff;
    logic [A_W-1:0]       a_last;
    logic [B_W-1:0]       b_last;

    // sequencer and datapath
    state_t                   state_reg, state_next;
    logic [ORIENT_W-1:0]      q_orient_reg, q_orient_next;
    logic [COORD_W-1:0]       qx_reg, qx_next;
    logic [COORD_W-1:0]       qy_reg, qy_next;
    logic [A_W-1:0]           a_reg, a_next;
    logic [B_W-1:0]           b_reg, b_next;
    logic [SC_W-1:0]          shift_reg, shift_next;
    logic signed [D_W-1:0]    dx_reg, dx_next;
    logic signed [D_W-1:0]    dy_reg, dy_next;
    logic [OI_W-1:0]          neg_reg, neg_next;
    logic [OI_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_WIDTH-1:0] best_reg, best_next;
    logic [SC_W-1:0]          best_shift_reg, best_shift_next;
    logic                     found_reg, found_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [SC_W-1:0]          pend_shift_reg, pend_shift_next;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_max_reg, out_max_next;
    logic [SHIFT_W-1:0]       out_shift_reg, out_shift_next;
    logic                     out_found_reg, out_found_next;

    logic                     in_accept;
    logic                     out_accept;
    logic                     orient_ok;
    logic [OI_W-1:0]          o_idx;
    logic [OI_W-1:0]          o_dec;
    logic [OI_W-1:0]          o_inc;
    logic [OI_W-1:0]          neg_dec;
    logic [OI_W-1:0]          pos_inc;
    logic [OI_W-1:0]          os;
    logic [A_W:0]             d_mag;
    logic signed [D_W-1:0]    d_val;
    logic signed [D_W-1:0]    offset;
    logic signed [P_W-1:0]    x1;
    logic signed [P_W-1:0]    y1;
    logic                     pos_ok;
    logic                     take;
    logic [COORD_W-1:0]       xm1;
    logic [COORD_W-1:0]       ym1;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;

    logic signed [VALUE_WIDTH-1:0] map_mem [MAP_DEPTH];

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign max_response = out_max_reg;
    assign best_shift   = out_shift_reg;
    assign found        = out_found_reg;

    assign w_eff  = (int'(width_reg) > MAX_SIZE) ? COORD_W'(MAX_SIZE) : width_reg;
    assign h_eff  = (int'(height_reg) > MAX_SIZE) ? COORD_W'(MAX_SIZE) : height_reg;
    assign l_eff  = (int'(loc_lim_reg) > MAX_LOC_SHIFT) ? LOC_LIM_W'(MAX_LOC_SHIFT) : loc_lim_reg;
    assign o_eff  = (int'(ori_lim_reg) > MAX_ORIENT_SHIFT) ? ORI_LIM_W'(MAX_ORIENT_SHIFT)
                                                          : ori_lim_reg;
    assign a_last = A_W'(l_eff) << 1;
    assign b_last = B_W'(o_eff) << 1;

    assign orient_ok = (int'(orient) < NUM_ORIENT);
    assign o_idx     = OI_W'(q_orient_reg);
    assign o_dec     = (o_idx == '0) ? OI_W'(NUM_ORIENT - 1) : o_idx - OI_W'(1);
    assign o_inc     = (o_idx == OI_W'(NUM_ORIENT - 1)) ? '0 : o_idx + OI_W'(1);
    assign neg_dec   = (neg_reg == '0) ? OI_W'(NUM_ORIENT - 1) : neg_reg - OI_W'(1);
    assign pos_inc   = (pos_reg == OI_W'(NUM_ORIENT - 1)) ? '0 : pos_reg + OI_W'(1);
    assign os        = (b_reg == '0) ? o_idx : (b_reg[0] ? neg_reg : pos_reg);

    assign d_mag = ({1'b0, a_reg} + (A_W+1)'(1)) >> 1;
    assign d_val = a_reg[0] ? -D_W'(d_mag) : D_W'(d_mag);

    olmp_offset_unit #(
        .NUM_ORIENT    (NUM_ORIENT),
        .MAX_LOC_SHIFT (MAX_LOC_SHIFT)
    ) u_offset (
        .sel_sin    (state_reg == S_MUL_Y),
        .orient_idx (o_idx),
        .step       (d_val),
        .offset     (offset)
    );

    assign x1     = signed'(P_W'(qx_reg)) + P_W'(dx_reg);
    assign y1     = signed'(P_W'(qy_reg)) + P_W'(dy_reg);
    assign pos_ok = (x1 >= P_W'(1)) && (x1 <= signed'(P_W'(w_eff)))
                 && (y1 >= P_W'(1)) && (y1 <= signed'(P_W'(h_eff)));
    assign take   = pend_valid_reg && (!found_reg || (rd_data_reg > best_reg));

    assign xm1     = x - COORD_W'(1);
    assign ym1     = y - COORD_W'(1);
    assign wr_en   = in_accept && (op == OP_WRITE) && orient_ok
                  && (x != '0) && (int'(x) <= MAX_SIZE)
                  && (y != '0) && (int'(y) <= MAX_SIZE);
    assign wr_addr = {OI_W'(orient), CI_W'(ym1), CI_W'(xm1)};
    assign rd_en   = (state_reg == S_SCAN) && pos_ok;
    assign rd_addr = {os, CI_W'(y1 - P_W'(1)), CI_W'(x1 - P_W'(1))};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            loc_lim_reg <= LOC_LIMIT_RST;
            ori_lim_reg <= ORI_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:        width_reg   <= cfg_data[COORD_W-1:0];
                CFG_HEIGHT:       height_reg  <= cfg_data[COORD_W-1:0];
                CFG_LOC_LIMIT:    loc_lim_reg <= cfg_data[LOC_LIM_W-1:0];
                CFG_ORIENT_LIMIT: ori_lim_reg <= cfg_data[ORI_LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (op == OP_QUERY))
                begin
                    state_next = orient_ok ? S_MUL_X : S_DONE;
                end
            end
            S_MUL_X: state_next = S_MUL_Y;
            S_MUL_Y: state_next = S_SCAN;
            S_SCAN:
            begin
                if (b_reg == b_last)
                begin
                    state_next = (a_reg == a_last) ? S_DRAIN : S_MUL_X;
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_orient_next   = q_orient_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        shift_next      = shift_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        best_next       = best_reg;
        best_shift_next = best_shift_reg;
        found_next      = found_reg;
        pend_valid_next = 1'b0;
        pend_shift_next = pend_shift_reg;
        out_valid_next  = out_accept ? 1'b0 : out_valid_reg;
        out_max_next    = out_max_reg;
        out_shift_next  = out_shift_reg;
        out_found_next  = out_found_reg;

        if (take)
        begin
            best_next       = rd_data_reg;
            best_shift_next = pend_shift_reg;
            found_next      = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (op == OP_QUERY))
                begin
                    q_orient_next   = orient;
                    qx_next         = x;
                    qy_next         = y;
                    a_next          = '0;
                    b_next          = '0;
                    shift_next      = '0;
                    best_next       = MIN_VAL;
                    best_shift_next = '0;
                    found_next      = 1'b0;
                end
            end
            S_MUL_X:
            begin
                dx_next  = offset;
                neg_next = o_dec;
                pos_next = o_inc;
            end
            S_MUL_Y:
            begin
                dy_next = offset;
            end
            S_SCAN:
            begin
                pend_valid_next = pos_ok;
                pend_shift_next = shift_reg;
                shift_next      = shift_reg + SC_W'(1);
                if (b_reg == b_last)
                begin
                    b_next = '0;
                    a_next = a_reg + A_W'(1);
                end
                else
                begin
                    b_next = b_reg + B_W'(1);
                    if (b_reg != '0)
                    begin
                        if (b_reg[0])
                        begin
                            neg_next = neg_dec;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                end
            end
            S_DRAIN: ;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_max_next   = best_reg;
                    out_shift_next = SHIFT_W'(best_shift_reg);
                    out_found_next = found_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_orient_reg   <= q_orient_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        shift_reg      <= shift_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        neg_reg        <= neg_next;
        pos_reg        <= pos_next;
        best_reg       <= best_next;
        best_shift_reg <= best_shift_next;
        found_reg      <= found_next;
        pend_shift_reg <= pend_shift_next;
        out_max_reg    <= out_max_next;
        out_shift_reg  <= out_shift_next;
        out_found_reg  <= out_found_next;
    end

    a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_QUERY) |=> state_reg != S_IDLE)
        else $error("query transaction did not start the sequencer");

    a_pending_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(state_reg) == S_SCAN)
        else $error("pending compare without a map read");

    a_not_found_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (max_response == MIN_VAL) && (best_shift == '0))
        else $error("empty pooling result carries a value");

endmodule

### dv/oriented_local_max_pooling_tb.sv
// Self-checking testbench for oriented_local_max_pooling: response writes and pooled queries
// checked against an in-bench predictor across several register settings.
// Depends on olmp_pkg and the oriented_local_max_pooling RTL.
module oriented_local_max_pooling_tb;
    import olmp_pkg::*;

    localparam int N_ORI        = NUM_ORIENT_DEF;
    localparam int SZ           = MAX_SIZE_DEF;
    localparam int MAXL         = MAX_LOC_SHIFT_DEF;
    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int MAP_DEPTH    = N_ORI * SZ * SZ;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_QUERY  = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 150;
    localparam int STUCK_LIMIT  = 4000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 3'd5;
    localparam logic signed [VW-1:0]   MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0]   MOST_POS = {1'b0, {(VW-1){1'b1}}};
    localparam longint                 FRAC_ONE  = 64'sd1 << 30;
    localparam longint unsigned        ANGLE_PI  = 64'd3373259426;

    typedef struct {
        op_t                  op;
        logic [ORIENT_W-1:0]  orient;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic signed [VW-1:0] value;
        bit                   drain;
    } map_access_t;

    typedef struct {
        logic signed [VW-1:0] max_response;
        logic [SHIFT_W-1:0]   best_shift;
        logic                 found;
    } pool_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      op = 1'b0;
    logic [ORIENT_W-1:0]       orient = '0;
    logic [COORD_W-1:0]        x = '0;
    logic [COORD_W-1:0]        y = '0;
    logic signed [VW-1:0]      value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VW-1:0]      max_response;
    logic [SHIFT_W-1:0]        best_shift;
    logic                      found;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    logic [COORD_W-1:0]        img_w = WIDTH_RST;
    logic [COORD_W-1:0]        img_h = HEIGHT_RST;
    logic [LOC_LIM_W-1:0]      loc_lim = LOC_LIMIT_RST;
    logic [ORI_LIM_W-1:0]      ori_lim = ORI_LIMIT_RST;

    int                        dx_tab [N_ORI][2*MAXL+1];
    int                        dy_tab [N_ORI][2*MAXL+1];
    logic signed [VW-1:0]      resp_mem [MAP_DEPTH];
    bit                        seeded [MAP_DEPTH];

    map_access_t               access_q [$];
    pool_t                     pooled_q [$];
    map_access_t               taken;
    pool_t                     want;
    bit                        in_taken = 1'b0;
    bit                        hold_req = 1'b0;
    int                        hold_left = 0;
    int                        mode_left = 0;
    int                        stall_mode = 0;
    int                        burst_left = 1;
    int                        gap_left = 0;
    int                        stuck_cycles = 0;
    int                        phase_items;
    int                        phase_queries;
    int                        n_writes = 0;
    int                        n_queries = 0;
    int                        n_results = 0;
    int                        n_errors = 0;

    int phase_regs [N_PHASES][4] = '{
        '{8, 8, 3, 1}, '{64, 64, 7, 3}, '{1, 1, 0, 0}, '{0, 5, 2, 1},
        '{127, 127, 5, 2}, '{12, 6, 7, 3}, '{20, 20, 1, 2}, '{4, 64, 4, 0}
    };

    oriented_local_max_pooling dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .orient       (orient),
        .x            (x),
        .y            (y),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .max_response (max_response),
        .best_shift   (best_shift),
        .found        (found),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int step_of(input int i);
        if (i == 0)
        begin
            return 0;
        end
        if ((i % 2) != 0)
        begin
            return -((i + 1) / 2);
        end
        return i / 2;
    endfunction

    function automatic int cell_of(input int o, input int cx, input int cy);
        return (o * SZ + cy - 1) * SZ + cx - 1;
    endfunction

    // map cell read by shift (a, b) of a query; 0 when it falls outside the image
    function automatic bit tap_addr(input int o, input int cx, input int cy, input int a,
                                    input int b, output int slot);
        int d;
        int os;
        int x1;
        int y1;
        int w;
        int h;
        d    = step_of(a);
        x1   = cx + dx_tab[o][d + MAXL];
        y1   = cy + dy_tab[o][d + MAXL];
        os   = (o + step_of(b)) % N_ORI;
        w    = (int'(img_w) > SZ) ? SZ : int'(img_w);
        h    = (int'(img_h) > SZ) ? SZ : int'(img_h);
        slot = 0;
        if (os < 0)
        begin
            os = os + N_ORI;
        end
        if (x1 < 1 || x1 > w || y1 < 1 || y1 > h)
        begin
            return 1'b0;
        end
        slot = cell_of(os, x1, y1);
        return 1'b1;
    endfunction

    function automatic pool_t pool_query(input int o, input int cx, input int cy);
        pool_t                r;
        int                   slot;
        int                   span;
        logic signed [VW-1:0] v;
        r.max_response = MOST_NEG;
        r.best_shift   = '0;
        r.found        = 1'b0;
        span           = 2 * int'(ori_lim) + 1;
        for (int a = 0; a <= 2 * int'(loc_lim); a++)
        begin
            for (int b = 0; b < span; b++)
            begin
                if (tap_addr(o, cx, cy, a, b, slot))
                begin
                    v = resp_mem[slot];
                    if (!r.found || v > r.max_response)
                    begin
                        r.max_response = v;
                        r.best_shift   = SHIFT_W'(a * span + b);
                        r.found        = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic signed [VW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return MOST_POS;
            1: return MOST_NEG;
            2, 3: return VW'($signed(VW'($urandom_range(0, 6))) - 3);
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic void push_access(input op_t kind, input int o, input int cx, input int cy,
                                        input logic signed [VW-1:0] v, input bit drain);
        map_access_t t;
        t.op     = kind;
        t.orient = o[ORIENT_W-1:0];
        t.x      = cx[COORD_W-1:0];
        t.y      = cy[COORD_W-1:0];
        t.value  = v;
        t.drain  = drain;
        access_q.push_back(t);
        if (kind == OP_QUERY)
        begin
            phase_items++;
        end
        else if (cx >= 1 && cx <= SZ && cy >= 1 && cy <= SZ)
        begin
            seeded[cell_of(o, cx, cy)] = 1'b1;
            phase_items++;
        end
    endfunction

    function automatic void push_cell(input int slot, input logic signed [VW-1:0] v);
        push_access(OP_WRITE, slot / (SZ * SZ), slot % SZ + 1, (slot / SZ) % SZ + 1, v, 1'b0);
    endfunction

    // write every unwritten cell the query will read, then issue the query
    function automatic void push_query(input int o, input int cx, input int cy, input bit flat,
                                       input logic signed [VW-1:0] flat_val, input bit drain);
        int slot;
        for (int a = 0; a <= 2 * int'(loc_lim); a++)
        begin
            for (int b = 0; b <= 2 * int'(ori_lim); b++)
            begin
                if (tap_addr(o, cx, cy, a, b, slot) && !seeded[slot])
                begin
                    push_cell(slot, flat ? flat_val : rand_sample());
                end
            end
        end
        push_access(OP_QUERY, o, cx, cy, VW'($urandom), drain);
        phase_queries++;
    endfunction

    function automatic void flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_WIDTH:        img_w   = val[COORD_W-1:0];
            CFG_HEIGHT:       img_h   = val[COORD_W-1:0];
            CFG_LOC_LIMIT:    loc_lim = val[LOC_LIM_W-1:0];
            CFG_ORIENT_LIMIT: ori_lim = val[ORI_LIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (access_q.size() != 0 || pooled_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // offset table: round(d * cos), round(d * sin) in Q30, halves rounded up
    initial
    begin : offset_rom
        int              p;
        int              a;
        int              b;
        bit              neg;
        bit              swp;
        longint          cc;
        longint          ss;
        longint          tmp;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned tc;
        longint unsigned ts;
        for (int o = 0; o < N_ORI; o++)
        begin
            p   = o;
            neg = 1'b0;
            swp = 1'b0;
            if (2 * p > N_ORI)
            begin
                p   = N_ORI - p;
                neg = 1'b1;
            end
            a = p;
            b = N_ORI;
            if (4 * p > N_ORI)
            begin
                a   = N_ORI - 2 * p;
                b   = 2 * N_ORI;
                swp = 1'b1;
            end
            if (a == 0)
            begin
                cc = FRAC_ONE;
                ss = 0;
            end
            else
            begin
                ang  = (ANGLE_PI * a) / b;
                ang2 = (ang * ang) >> 30;
                tc   = FRAC_ONE;
                ts   = ang;
                cc   = FRAC_ONE;
                ss   = longint'(ang);
                for (int k = 1; k <= 10; k++)
                begin
                    tc = ((tc * ang2) >> 30) / ((2 * k - 1) * (2 * k));
                    ts = ((ts * ang2) >> 30) / ((2 * k) * (2 * k + 1));
                    if ((k % 2) != 0)
                    begin
                        cc = cc - longint'(tc);
                        ss = ss - longint'(ts);
                    end
                    else
                    begin
                        cc = cc + longint'(tc);
                        ss = ss + longint'(ts);
                    end
                end
                if (6 * a == b)
                begin
                    ss = FRAC_ONE / 2;
                end
            end
            if (swp)
            begin
                tmp = cc;
                cc  = ss;
                ss  = tmp;
            end
            if (neg)
            begin
                cc = -cc;
            end
            for (int d = -MAXL; d <= MAXL; d++)
            begin
                dx_tab[o][d + MAXL] = int'((longint'(d) * cc + FRAC_ONE / 2) >>> 30);
                dy_tab[o][d + MAXL] = int'((longint'(d) * ss + FRAC_ONE / 2) >>> 30);
            end
        end
    end

    // input side: accept and predict
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            taken    = access_q.pop_front();
            in_taken = 1'b1;
            if (taken.op == OP_QUERY)
            begin
                pooled_q.push_back(pool_query(taken.orient, taken.x, taken.y));
                n_queries++;
            end
            else
            begin
                if (taken.x >= 1 && taken.x <= SZ && taken.y >= 1 && taken.y <= SZ)
                begin
                    resp_mem[cell_of(taken.orient, taken.x, taken.y)] = taken.value;
                end
                n_writes++;
            end
        end
    end

    // input side: offer items in bursts
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (rst_n && gap_left == 0 && access_q.size() != 0 &&
                !(access_q[0].drain && pooled_q.size() != 0))
            begin
                op       <= access_q[0].op;
                orient   <= access_q[0].orient;
                x        <= access_q[0].x;
                y        <= access_q[0].y;
                value    <= access_q[0].value;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                end
            end
        end
    end

    // output side: stall pattern and requested hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(32, 256);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((mode_left % 3) == 0);
            endcase
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pooled_q.size() == 0)
            begin
                flag_error($sformatf("unexpected result max %0d shift %0d found %0b",
                                     max_response, best_shift, found));
            end
            else
            begin
                want = pooled_q.pop_front();
                if (max_response !== want.max_response || best_shift !== want.best_shift ||
                    found !== want.found)
                begin
                    flag_error($sformatf(
                        "result %0d: expected max %0d shift %0d found %0b, got %0d %0d %0b",
                        n_results, want.max_response, want.best_shift, want.found,
                        max_response, best_shift, found));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int first_cell;
        int last_cell;
        int slot;
        int ax;
        int ay;
        int w_eff;
        int h_eff;
        int o;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase_items   = 0;
        phase_queries = 0;
        push_access(OP_WRITE, 0, 1, 1, MOST_NEG, 1'b0);
        push_access(OP_WRITE, N_ORI - 1, SZ, SZ, MOST_POS, 1'b0);
        push_access(OP_WRITE, 3, 0, 5, 16'sd1, 1'b0);
        push_access(OP_WRITE, 3, 5, 0, -16'sd1, 1'b0);
        push_access(OP_WRITE, 7, 127, 127, 16'sh5555, 1'b0);
        push_access(OP_WRITE, 2, SZ + 1, SZ, 16'shAAAA, 1'b0);
        push_access(OP_WRITE, 12, SZ, SZ + 1, 16'sd9, 1'b0);
        push_query(0, 1, 1, 1'b0, '0, 1'b0);
        push_query(N_ORI - 1, SZ, SZ, 1'b0, '0, 1'b0);
        push_query(5, 0, 0, 1'b0, '0, 1'b0);
        push_query(9, 127, 127, 1'b0, '0, 1'b0);
        // ties everywhere, then a peak at the last shift, then an equal peak at the first
        push_query(4, 32, 32, 1'b1, 16'sd7, 1'b0);
        first_cell = -1;
        last_cell  = -1;
        for (int a = 0; a <= 2 * int'(loc_lim); a++)
        begin
            for (int b = 0; b <= 2 * int'(ori_lim); b++)
            begin
                if (tap_addr(4, 32, 32, a, b, slot))
                begin
                    if (first_cell < 0)
                    begin
                        first_cell = slot;
                    end
                    last_cell = slot;
                end
            end
        end
        push_cell(last_cell, MOST_POS);
        push_query(4, 32, 32, 1'b0, '0, 1'b0);
        push_cell(first_cell, MOST_POS);
        push_query(4, 32, 32, 1'b0, '0, 1'b1);

        for (int p = 0; p <= N_PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_quiet();
                write_reg(CFG_WIDTH, phase_regs[p-1][0]);
                write_reg(CFG_HEIGHT, phase_regs[p-1][1]);
                write_reg(CFG_LOC_LIMIT, phase_regs[p-1][2]);
                write_reg(CFG_ORIENT_LIMIT, phase_regs[p-1][3]);
                if (p == 3)
                begin
                    write_reg(CFG_UNUSED_IDX, 127);
                end
                @(posedge clk);
            end
            w_eff         = (int'(img_w) > SZ) ? SZ : int'(img_w);
            h_eff         = (int'(img_h) > SZ) ? SZ : int'(img_h);
            ax            = $urandom_range(1, (w_eff < 1) ? 1 : w_eff);
            ay            = $urandom_range(1, (h_eff < 1) ? 1 : h_eff);
            phase_items   = 0;
            phase_queries = 0;
            while (phase_items < PHASE_ITEMS || phase_queries < PHASE_QUERY)
            begin
                o = $urandom_range(0, N_ORI - 1);
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        push_query(o, ax + $urandom_range(0, 2) - 1, ay + $urandom_range(0, 2) - 1,
                                   1'b0, '0, 1'b0);
                    8, 9, 10, 11:
                        push_access(OP_WRITE, o, $urandom_range(1, SZ), $urandom_range(1, SZ),
                                    rand_sample(), 1'b0);
                    12:
                        push_access(OP_WRITE, o, $urandom_range(0, 127), $urandom_range(0, 127),
                                    rand_sample(), 1'b0);
                    13:
                        push_query(o, $urandom_range(0, 127), $urandom_range(0, 127),
                                   1'b0, '0, 1'b0);
                    14:
                        push_query(o, ax + $urandom_range(0, 2) - 1, ay, 1'b0, '0, 1'b1);
                    default:
                        push_query(o, ax, ay + $urandom_range(0, 2) - 1, 1'b1, rand_sample(),
                                   1'b0);
                endcase
            end
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
        end

        wait_quiet();
        $display("summary: %0d writes, %0d queries, %0d pooled results over %0d register settings",
                 n_writes, n_queries, n_results, N_PHASES + 1);
        $display("summary: %0d errors", n_errors);
        if (n_errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### oriented_local_max_pooling.f
rtl/olmp_pkg.sv
rtl/olmp_offset_unit.sv
rtl/oriented_local_max_pooling.sv
dv/oriented_local_max_pooling_tb.sv
